FILE: src/c8_pkg.sv
package c8_pkg;

    localparam int MEM_BYTES_DEF  = 4096;
    localparam int SCR_W          = 64;
    localparam int SCR_H          = 32;
    localparam int STACK_DEF      = 16;
    localparam logic [11:0] RESET_START = 12'h200;
    localparam int FONT_BYTES     = 80;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_EXEC  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_WRITE, ST_FETCH_HI, ST_FETCH_LO, ST_FETCH_WAIT,
        ST_EXEC, ST_CLEAR, ST_DRAW_RD, ST_DRAW_WAIT, ST_DRAW_MOD, ST_BCD,
        ST_STORE, ST_LOAD_RD, ST_LOAD_WAIT, ST_LOAD_WR, ST_FINISH, ST_OUT
    } state_t;

    // command from controller to datapath
    typedef struct packed {
        logic init_step;
        logic accept;
        logic mem_write_in;
        logic rd_hi;
        logic rd_lo;
        logic latch_hi;
        logic latch_lo;
        logic exec;
        logic clear_step;
        logic draw_rd;
        logic draw_mod;
        logic bcd_step;
        logic store_step;
        logic load_rd;
        logic load_wr;
        logic finish;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic init_done;
        logic [1:0] kind;
        logic [3:0] op_class;
        logic [7:0] kk;
        logic cnt_last;
        logic draw_zero;
        logic bcd_last;
    } stat_t;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] f [0:79];
        f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        if (a < 7'(FONT_BYTES)) return f[a];
        return 8'h00;
    endfunction

endpackage

FILE: src/c8_ctrl.sv
module c8_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           m_tready,
    output logic           s_tready,
    output logic           m_tvalid,
    input  c8_pkg::stat_t  st,
    output c8_pkg::cmd_t   cmd
);

    c8_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= c8_pkg::ST_INIT;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            c8_pkg::ST_INIT:      if (st.init_done) state_next = c8_pkg::ST_IDLE;
            c8_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    priority case (st.kind)
                        c8_pkg::KIND_WRITE: state_next = c8_pkg::ST_WRITE;
                        c8_pkg::KIND_EXEC:  state_next = c8_pkg::ST_FETCH_HI;
                        default:            state_next = c8_pkg::ST_FINISH;
                    endcase
                end
            end
            c8_pkg::ST_WRITE:      state_next = c8_pkg::ST_FINISH;
            c8_pkg::ST_FETCH_HI:   state_next = c8_pkg::ST_FETCH_LO;
            c8_pkg::ST_FETCH_LO:   state_next = c8_pkg::ST_FETCH_WAIT;
            c8_pkg::ST_FETCH_WAIT: state_next = c8_pkg::ST_EXEC;
            c8_pkg::ST_EXEC: begin
                priority if (st.op_class == 4'h0 && st.kk == 8'hE0)
                    state_next = c8_pkg::ST_CLEAR;
                else if (st.op_class == 4'hD)
                    state_next = st.draw_zero ? c8_pkg::ST_FINISH : c8_pkg::ST_DRAW_RD;
                else if (st.op_class == 4'hF && st.kk == 8'h33)
                    state_next = c8_pkg::ST_BCD;
                else if (st.op_class == 4'hF && st.kk == 8'h55)
                    state_next = c8_pkg::ST_STORE;
                else if (st.op_class == 4'hF && st.kk == 8'h65)
                    state_next = c8_pkg::ST_LOAD_RD;
                else
                    state_next = c8_pkg::ST_FINISH;
            end
            c8_pkg::ST_CLEAR:     if (st.cnt_last) state_next = c8_pkg::ST_FINISH;
            c8_pkg::ST_DRAW_RD:   state_next = c8_pkg::ST_DRAW_WAIT;
            c8_pkg::ST_DRAW_WAIT: state_next = c8_pkg::ST_DRAW_MOD;
            c8_pkg::ST_DRAW_MOD:
                state_next = st.cnt_last ? c8_pkg::ST_FINISH : c8_pkg::ST_DRAW_RD;
            c8_pkg::ST_BCD:       if (st.bcd_last) state_next = c8_pkg::ST_FINISH;
            c8_pkg::ST_STORE:     if (st.cnt_last) state_next = c8_pkg::ST_FINISH;
            c8_pkg::ST_LOAD_RD:   state_next = c8_pkg::ST_LOAD_WAIT;
            c8_pkg::ST_LOAD_WAIT: state_next = c8_pkg::ST_LOAD_WR;
            c8_pkg::ST_LOAD_WR:
                state_next = st.cnt_last ? c8_pkg::ST_FINISH : c8_pkg::ST_LOAD_RD;
            c8_pkg::ST_FINISH:    state_next = c8_pkg::ST_OUT;
            c8_pkg::ST_OUT:       if (m_tready) state_next = c8_pkg::ST_IDLE;
            default:              state_next = c8_pkg::ST_INIT;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            c8_pkg::ST_INIT:       cmd.init_step = 1'b1;
            c8_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            c8_pkg::ST_WRITE:      cmd.mem_write_in = 1'b1;
            c8_pkg::ST_FETCH_HI:   cmd.rd_hi = 1'b1;
            c8_pkg::ST_FETCH_LO: begin
                cmd.rd_lo    = 1'b1;
                cmd.latch_hi = 1'b1;
            end
            c8_pkg::ST_FETCH_WAIT: cmd.latch_lo = 1'b1;
            c8_pkg::ST_EXEC:       cmd.exec = 1'b1;
            c8_pkg::ST_CLEAR:      cmd.clear_step = 1'b1;
            c8_pkg::ST_DRAW_RD:    cmd.draw_rd = 1'b1;
            c8_pkg::ST_DRAW_WAIT:  ;
            c8_pkg::ST_DRAW_MOD:   cmd.draw_mod = 1'b1;
            c8_pkg::ST_BCD:        cmd.bcd_step = 1'b1;
            c8_pkg::ST_STORE:      cmd.store_step = 1'b1;
            c8_pkg::ST_LOAD_RD:    cmd.load_rd = 1'b1;
            c8_pkg::ST_LOAD_WAIT:  ;
            c8_pkg::ST_LOAD_WR:    cmd.load_wr = 1'b1;
            c8_pkg::ST_FINISH:     cmd.finish = 1'b1;
            c8_pkg::ST_OUT:        m_tvalid = 1'b1;
            default:               ;
        endcase
        cmd.out_load = (state_reg == c8_pkg::ST_FINISH);
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_out_follows_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == c8_pkg::ST_FINISH))
        else $error("result without finish");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("idle after accept");
`endif

endmodule

FILE: src/c8_datapath.sv
module c8_datapath #(
    parameter int MEM_BYTES = c8_pkg::MEM_BYTES_DEF,
    parameter int STACK_D   = c8_pkg::STACK_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  c8_pkg::cmd_t   cmd,
    output c8_pkg::stat_t  st,
    input  logic           cfg_we,
    input  logic [11:0]    cfg_wdata,
    input  logic [1:0]     in_kind,
    input  logic [11:0]    in_address,
    input  logic [7:0]     in_write_byte,
    input  logic [15:0]    in_key_states,
    input  logic [7:0]     in_random_byte,
    input  logic [4:0]     in_row_index,
    output logic [15:0]    out_pc_now,
    output logic [15:0]    out_opcode,
    output logic           out_draw,
    output logic           out_sound,
    output logic           out_unknown,
    output logic           out_wait,
    output logic [63:0]    out_row
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int SW = $clog2(STACK_D);

    // memories
    logic [7:0]  mem [0:MEM_BYTES-1];
    logic [63:0] frame [0:c8_pkg::SCR_H-1];
    logic [15:0] stack [0:STACK_D-1];
    logic [7:0]  vreg [0:15];

    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata_reg;
    logic          mem_we, mem_re;
    logic [4:0]    fr_waddr, fr_raddr;
    logic [63:0]   fr_wdata, fr_rdata_reg;
    logic          fr_we, fr_re;

    // item registers
    logic [1:0]  kind_reg;
    logic [11:0] addr_reg;
    logic [7:0]  wbyte_reg, rnd_reg;
    logic [15:0] keys_reg;
    logic [11:0] pc_reg;
    logic [15:0] i_reg, op_reg;
    logic [SW-1:0] sp_reg;
    logic [7:0]  dt_reg, stm_reg;
    logic [AW:0] init_reg;
    logic [4:0]  cnt_reg;
    logic        hit_reg, draw_reg, unk_reg, wait_reg;
    logic [7:0]  bcd_val_reg;
    logic [1:0]  bcd_cnt_reg;
    logic [11:0] next_reg;

    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy;
    assign x  = op_reg[11:8];
    assign y  = op_reg[7:4];
    assign n  = op_reg[3:0];
    assign kk = op_reg[7:0];
    assign vx = vreg[x];
    assign vy = vreg[y];

    // sprite row after shift, wrapped at the right edge
    logic [5:0]   cx;
    logic [4:0]   cy, drow;
    logic [127:0] spr_wide;
    logic [63:0]  spr_mask;
    assign cx       = vx[5:0];
    assign cy       = vy[4:0];
    assign drow     = cy + cnt_reg;
    assign spr_wide = {mem_rdata_reg, 120'd0} >> cx;
    assign spr_mask = spr_wide[127:64] | spr_wide[63:0];

    logic [AW-1:0] i_off;
    assign i_off = i_reg[AW-1:0] + AW'(cnt_reg);

    // decimal digits: compare for hundreds, reciprocal multiply for tens
    logic [7:0]  bcd_hund, bcd_rem, bcd_tens, bcd_ones;
    logic [15:0] bcd_prod;
    assign bcd_hund = (bcd_val_reg >= 8'd200) ? 8'd2 : (bcd_val_reg >= 8'd100) ? 8'd1 : 8'd0;
    assign bcd_rem  = bcd_val_reg - ((bcd_val_reg >= 8'd200) ? 8'd200 :
                                     (bcd_val_reg >= 8'd100) ? 8'd100 : 8'd0);
    assign bcd_prod = {8'd0, bcd_rem} * 16'd205;
    assign bcd_tens = {3'd0, bcd_prod[15:11]};
    assign bcd_ones = bcd_rem - {bcd_tens[4:0], 3'b000} - {bcd_tens[6:0], 1'b0};

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = i_off;
        mem_wdata = 8'h00;
        mem_re    = 1'b0;
        mem_raddr = i_off;
        priority if (cmd.init_step) begin
            mem_we    = 1'b1;
            mem_waddr = init_reg[AW-1:0];
            mem_wdata = c8_pkg::font_byte(init_reg[AW-1:7] == '0 ? init_reg[6:0] : 7'h7F);
        end else if (cmd.mem_write_in) begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg[AW-1:0];
            mem_wdata = wbyte_reg;
        end else if (cmd.bcd_step) begin
            mem_we    = 1'b1;
            mem_waddr = i_reg[AW-1:0] + AW'(bcd_cnt_reg);
            unique case (bcd_cnt_reg)
                2'd0:    mem_wdata = bcd_hund;
                2'd1:    mem_wdata = bcd_tens;
                default: mem_wdata = bcd_ones;
            endcase
        end else if (cmd.store_step) begin
            mem_we    = 1'b1;
            mem_wdata = vreg[cnt_reg[3:0]];
        end else if (cmd.rd_hi) begin
            mem_re    = 1'b1;
            mem_raddr = pc_reg[AW-1:0];
        end else if (cmd.rd_lo) begin
            mem_re    = 1'b1;
            mem_raddr = pc_reg[AW-1:0] + AW'(1);
        end else if (cmd.draw_rd || cmd.load_rd) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_rdata_reg <= mem[mem_raddr];
    end

    // frame port control
    always_comb begin
        fr_we    = 1'b0;
        fr_waddr = drow;
        fr_wdata = fr_rdata_reg ^ spr_mask;
        fr_re    = cmd.draw_rd || cmd.accept;
        fr_raddr = cmd.accept ? in_row_index : drow;
        if (cmd.init_step || cmd.clear_step) begin
            fr_we    = 1'b1;
            fr_waddr = cmd.init_step ? init_reg[4:0] : cnt_reg;
            fr_wdata = 64'd0;
        end else if (cmd.draw_mod) begin
            fr_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fr_we) frame[fr_waddr] <= fr_wdata;
        if (fr_re) fr_rdata_reg <= frame[fr_raddr];
    end

    // execute decode
    logic [11:0] pc2, pc4, nxt;
    logic        unk, wt, skip;
    logic [8:0]  sum9;
    logic [3:0]  keyi;
    logic        keyfound;
    assign pc2  = pc_reg + 12'd2;
    assign pc4  = pc_reg + 12'd4;
    assign sum9 = {1'b0, vx} + {1'b0, vy};

    always_comb begin
        keyi = 4'd0;
        keyfound = 1'b0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                keyi = 4'(k);
                keyfound = 1'b1;
            end
        end
    end

    always_comb begin
        unk  = 1'b0;
        wt   = 1'b0;
        skip = 1'b0;
        nxt  = pc2;
        unique case (op_reg[15:12])
            4'h0: if (op_reg == 16'h00EE) nxt = stack[sp_reg][11:0] + 12'd2;
                  else if (op_reg != 16'h00E0) unk = 1'b1;
            4'h1, 4'h2: nxt = op_reg[11:0];
            4'h3: skip = (vx == kk);
            4'h4: skip = (vx != kk);
            4'h5: skip = (vx == vy);
            4'h8: if (!(n <= 4'h7 || n == 4'hE)) unk = 1'b1;
            4'h9: skip = (vx != vy);
            4'hB: nxt = op_reg[11:0] + {4'd0, vreg[0]};
            4'hE: if (kk == 8'h9E) skip = keys_reg[vx[3:0]];
                  else if (kk == 8'hA1) skip = !keys_reg[vx[3:0]];
                  else unk = 1'b1;
            4'hF: begin
                if (kk == 8'h0A) wt = !keyfound;
                else if (!(kk == 8'h07 || kk == 8'h15 || kk == 8'h18 || kk == 8'h1E ||
                           kk == 8'h29 || kk == 8'h33 || kk == 8'h55 || kk == 8'h65))
                    unk = 1'b1;
            end
            default: ;
        endcase
        if (skip) nxt = pc4;
        if (unk || wt) nxt = pc_reg;
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg  <= '0;
            pc_reg    <= c8_pkg::RESET_START;
            i_reg     <= '0;
            sp_reg    <= '0;
            dt_reg    <= '0;
            stm_reg   <= '0;
            for (int k = 0; k < 16; k++) vreg[k] <= '0;
            for (int k = 0; k < STACK_D; k++) stack[k] <= '0;
        end else begin
            if (cmd.init_step && !init_reg[AW]) init_reg <= init_reg + 1'b1;
            if (cfg_we) pc_reg <= cfg_wdata;
            if (cmd.accept) begin
                kind_reg  <= in_kind;
                addr_reg  <= in_address;
                wbyte_reg <= in_write_byte;
                keys_reg  <= in_key_states;
                rnd_reg   <= in_random_byte;
                op_reg    <= '0;
                draw_reg  <= 1'b0;
                unk_reg   <= 1'b0;
                wait_reg  <= 1'b0;
                hit_reg   <= 1'b0;
                cnt_reg   <= '0;
                bcd_cnt_reg <= '0;
            end
            if (cmd.latch_hi) op_reg[15:8] <= mem_rdata_reg;
            if (cmd.latch_lo) op_reg[7:0]  <= mem_rdata_reg;
            if (cmd.exec) begin
                next_reg    <= nxt;
                unk_reg     <= unk;
                wait_reg    <= wt;
                bcd_val_reg <= vx;
                cnt_reg     <= '0;
                unique case (op_reg[15:12])
                    4'h0: if (op_reg == 16'h00EE) sp_reg <= sp_reg - 1'b1;
                    4'h2: begin
                        sp_reg <= sp_reg + 1'b1;
                        stack[sp_reg + 1'b1] <= {4'd0, pc_reg};
                    end
                    4'h6: vreg[x] <= kk;
                    4'h7: vreg[x] <= vx + kk;
                    4'h8: begin
                        // the flag wins over the result when x is VF
                        unique case (n)
                            4'h0: vreg[x] <= vy;
                            4'h1: vreg[x] <= vx | vy;
                            4'h2: vreg[x] <= vx & vy;
                            4'h3: vreg[x] <= vx ^ vy;
                            4'h4: begin
                                if (x != 4'hF) vreg[x] <= sum9[7:0];
                                vreg[15] <= {7'd0, sum9[8]};
                            end
                            4'h5: begin
                                if (x != 4'hF) vreg[x] <= vx - vy;
                                vreg[15] <= {7'd0, vx >= vy};
                            end
                            4'h6: begin
                                if (x != 4'hF) vreg[x] <= {1'b0, vx[7:1]};
                                vreg[15] <= {7'd0, vx[0]};
                            end
                            4'h7: begin
                                if (x != 4'hF) vreg[x] <= vy - vx;
                                vreg[15] <= {7'd0, vy >= vx};
                            end
                            4'hE: begin
                                if (x != 4'hF) vreg[x] <= {vx[6:0], 1'b0};
                                vreg[15] <= {7'd0, vx[7]};
                            end
                            default: ;
                        endcase
                    end
                    4'hA: i_reg <= {4'd0, op_reg[11:0]};
                    4'hC: vreg[x] <= rnd_reg & kk;
                    4'hD: draw_reg <= 1'b1;
                    4'hF: begin
                        if (kk == 8'h07) vreg[x] <= dt_reg;
                        else if (kk == 8'h0A && keyfound) vreg[x] <= {4'd0, keyi};
                        else if (kk == 8'h15) dt_reg <= vx;
                        else if (kk == 8'h18) stm_reg <= vx;
                        else if (kk == 8'h1E) i_reg <= i_reg + {8'd0, vx};
                        else if (kk == 8'h29) i_reg <= {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
                    end
                    default: ;
                endcase
            end
            if (cmd.clear_step || cmd.store_step || cmd.load_wr) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.draw_mod) begin
                cnt_reg <= cnt_reg + 1'b1;
                if ((fr_rdata_reg & spr_mask) != 64'd0) hit_reg <= 1'b1;
            end
            if (cmd.load_wr) vreg[cnt_reg[3:0]] <= mem_rdata_reg;
            if (cmd.bcd_step) bcd_cnt_reg <= bcd_cnt_reg + 1'b1;
            if (cmd.finish && kind_reg == c8_pkg::KIND_EXEC) begin
                pc_reg <= next_reg;
                if (draw_reg) vreg[15] <= {7'd0, hit_reg};
                if (dt_reg != 8'd0) dt_reg <= dt_reg - 1'b1;
                if (stm_reg != 8'd0) stm_reg <= stm_reg - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_pc_now  <= {4'd0, (kind_reg == c8_pkg::KIND_EXEC) ? next_reg : pc_reg};
            out_opcode  <= (kind_reg == c8_pkg::KIND_EXEC) ? op_reg : 16'd0;
            out_draw    <= (kind_reg == c8_pkg::KIND_EXEC) && draw_reg;
            out_sound   <= (kind_reg == c8_pkg::KIND_EXEC) && (stm_reg != 8'd0);
            out_unknown <= (kind_reg == c8_pkg::KIND_EXEC) && unk_reg;
            out_wait    <= (kind_reg == c8_pkg::KIND_EXEC) && wait_reg;
            out_row     <= (kind_reg == c8_pkg::KIND_READ) ? fr_rdata_reg : 64'd0;
        end
    end

    // status
    logic [4:0] last_cnt;
    always_comb begin
        last_cnt = 5'd31;
        if (cmd.store_step || cmd.load_wr) last_cnt = {1'b0, x};
        else if (cmd.draw_mod) last_cnt = {1'b0, n} - 5'd1;
    end
    assign st.init_done = init_reg[AW];
    assign st.kind      = cmd.accept ? in_kind : kind_reg;
    assign st.op_class  = op_reg[15:12];
    assign st.kk        = kk;
    assign st.cnt_last  = (cnt_reg == last_cnt);
    assign st.draw_zero = (n == 4'd0);
    assign st.bcd_last  = (bcd_cnt_reg == 2'd2);

`ifndef SYNTHESIS
    a_sp_call: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && op_reg[15:12] == 4'h2) |=> sp_reg == $past(sp_reg) + 1'b1)
        else $error("call did not advance sp");
    a_pc_hold_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && unk) |=> next_reg == $past(pc_reg)) else $error("pc moved");
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.mem_write_in && cmd.store_step)) else $error("two memory writers");
`endif

endmodule

FILE: src/chip8_instruction_core.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tuser kind, s_tdata address..row_index
// m_       out  m_tvalid/m_tready  m_tdata pc_now..row_pixels
// cfg      in   cfg_we             cfg_wdata start_address
// From an item's transfer to its result transfer the controller walks the
// memory and frame ports: clear, Fx33 and Fx55 write one row or byte a cycle;
// draw reads, waits on and rewrites each row, Fx65 reads, waits on and writes
// each byte. After reset a clearing pass loads the font and clears memory and
// frame; no item is taken meanwhile. The result is held until taken, and the
// next item is accepted in the cycle after the result transfer.
module chip8_instruction_core #(
    parameter int MEM_BYTES = c8_pkg::MEM_BYTES_DEF,
    parameter int STACK_D   = c8_pkg::STACK_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // kind
    input  logic [55:0]  s_tdata,   // address, write_byte, key_states, random_byte, row_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // pc_now, fetched_opcode, sprite_drawn, tone_on,
                                    // unknown_opcode, waiting_for_key, row_pixels
    input  logic         cfg_we,
    input  logic [11:0]  cfg_wdata
);

    c8_pkg::cmd_t  cmd;
    c8_pkg::stat_t st;

    c8_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .m_tready, .s_tready, .m_tvalid, .st, .cmd
    );

    c8_datapath #(.MEM_BYTES(MEM_BYTES), .STACK_D(STACK_D)) u_dp (
        .aclk, .aresetn, .cmd, .st, .cfg_we, .cfg_wdata,
        .in_kind(s_tuser),
        .in_address(s_tdata[11:0]),
        .in_write_byte(s_tdata[19:12]),
        .in_key_states(s_tdata[35:20]),
        .in_random_byte(s_tdata[43:36]),
        .in_row_index(s_tdata[48:44]),
        .out_pc_now(m_tdata[15:0]),
        .out_opcode(m_tdata[31:16]),
        .out_draw(m_tdata[32]),
        .out_sound(m_tdata[33]),
        .out_unknown(m_tdata[34]),
        .out_wait(m_tdata[35]),
        .out_row(m_tdata[99:36])
    );

    assign m_tdata[103:100] = 4'd0;

endmodule
